/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/alae_pkg.sv */
`timescale 1ns / 1ps
package alae_pkg;
    localparam int GRID_SIDE = 8;
    localparam int NPIX      = GRID_SIDE * GRID_SIDE;
    localparam int NPIX_LOG  = $clog2(NPIX);
    localparam int SUM_W     = 16 + NPIX_LOG;
    localparam int CNT_W     = $clog2(NPIX + 1);
    localparam int W_W       = SUM_W + 17;
    localparam int DIV_W     = W_W + 16;
    localparam int ROOTS     = 10;

    localparam logic [15:0] WEIGHT_RED   = 16'd19661;
    localparam logic [15:0] WEIGHT_GREEN = 16'd38666;
    localparam logic [15:0] WEIGHT_BLUE  = 16'd7209;
    localparam logic [15:0] RST_TARGET   = 16'd1229;
    localparam logic [15:0] RST_SPEED    = 16'd32768;
    localparam logic [15:0] RST_MIN      = 16'd1024;
    localparam logic [15:0] RST_MAX      = 16'd16384;
    localparam logic [15:0] EXP_ONE      = 16'd4096;
    localparam logic [15:0] EXP_SAT      = 16'hFFFF;
    localparam logic [16:0] ONE_Q16      = 17'h10000;

    typedef enum logic [1:0] {
        CFG_TARGET,
        CFG_SPEED,
        CFG_MIN,
        CFG_MAX
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_WSUM,
        OP_DINIT,
        OP_DIV,
        OP_SINIT,
        OP_SQRT,
        OP_PINIT,
        OP_POW,
        OP_BL1,
        OP_BL2
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       acc;
        logic [3:0] step;
        logic [3:0] root;
    } t_cmd;
endpackage

/* design/alae_if.sv */
`timescale 1ns / 1ps
interface alae_pix_if;
    logic        valid;
    logic        ready;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] elapsed_time;
    modport source (output valid, red, green, blue, elapsed_time, input ready);
    modport sink   (input valid, red, green, blue, elapsed_time, output ready);
endinterface

interface alae_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] new_exposure;
    logic        luminance_zero;
    modport source (output valid, new_exposure, luminance_zero, input ready);
    modport sink   (input valid, new_exposure, luminance_zero, output ready);
endinterface

/* design/alae_ctrl.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module alae_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output alae_pkg::t_cmd o_cmd
);
    import alae_pkg::*;

    typedef enum logic [3:0] {
        ST_ACC, ST_WSUM, ST_DINIT, ST_DIV, ST_SINIT, ST_SQRT,
        ST_PINIT, ST_POW, ST_BL1, ST_BL2
    } t_state;

    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NPIX - 1);
    localparam logic [3:0]       LAST_ROOT = 4'(ROOTS);

    t_state            r_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [3:0]        r_step;
    logic [3:0]        r_k;
    logic              r_out_valid;
    logic              in_xfer;

    assign o_in_ready  = (r_state == ST_ACC) && !(r_out_valid && r_cnt == LAST_CNT);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.acc  = in_xfer;
        o_cmd.step = r_step;
        o_cmd.root = r_k;
        case (r_state)
            ST_WSUM:  o_cmd.op = OP_WSUM;
            ST_DINIT: o_cmd.op = OP_DINIT;
            ST_DIV:   o_cmd.op = OP_DIV;
            ST_SINIT: o_cmd.op = OP_SINIT;
            ST_SQRT:  o_cmd.op = OP_SQRT;
            ST_PINIT: o_cmd.op = OP_PINIT;
            ST_POW:   o_cmd.op = OP_POW;
            ST_BL1:   o_cmd.op = OP_BL1;
            ST_BL2:   o_cmd.op = OP_BL2;
            default:  o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ACC;
            r_cnt       <= '0;
            r_step      <= '0;
            r_k         <= 4'd1;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_ACC: begin
                    if (in_xfer) begin
                        if (r_cnt == LAST_CNT) begin
                            r_cnt   <= '0;
                            r_step  <= '0;
                            r_state <= ST_WSUM;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                ST_WSUM: begin
                    if (r_step == 4'd2) begin
                        r_state <= ST_DINIT;
                    end
                    r_step <= r_step + 1'b1;
                end
                ST_DINIT: begin
                    r_step  <= 4'd15;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (r_step == 4'd0) begin
                        r_k     <= 4'd1;
                        r_state <= ST_SINIT;
                    end
                    r_step <= r_step - 1'b1;
                end
                ST_SINIT: begin
                    r_step  <= 4'd15;
                    r_state <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (r_step == 4'd0) begin
                        if (r_k == LAST_ROOT) begin
                            r_state <= ST_PINIT;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= ST_SINIT;
                        end
                    end
                    r_step <= r_step - 1'b1;
                end
                ST_PINIT: begin
                    r_step  <= 4'd0;
                    r_state <= ST_POW;
                end
                ST_POW: begin
                    if (r_step == 4'd15) begin
                        r_state <= ST_BL1;
                    end
                    r_step <= r_step + 1'b1;
                end
                ST_BL1: begin
                    r_state <= ST_BL2;
                end
                ST_BL2: begin
                    r_out_valid <= 1'b1;
                    r_state     <= ST_ACC;
                end
                default: r_state <= ST_ACC;
            endcase
        end
    end

    `AST_NXT(a_result_raised, r_state == ST_BL2, r_out_valid)
    `AST_IMP(a_last_not_pending, in_xfer && r_cnt == LAST_CNT, !r_out_valid)
    `AST_IMP(a_root_range, 1'b1, r_k >= 4'd1 && r_k <= LAST_ROOT)
    `AST_NXT(a_roots_done, r_state == ST_SQRT && r_step == 4'd0 && r_k == LAST_ROOT,
        r_state == ST_PINIT)
endmodule

/* design/alae_dp.sv */
`timescale 1ns / 1ps
module alae_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  alae_pkg::t_cmd i_cmd,
    input  logic [15:0]    i_red,
    input  logic [15:0]    i_green,
    input  logic [15:0]    i_blue,
    input  logic [15:0]    i_elapsed,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [15:0]    i_cfg_data,
    output logic [15:0]    o_exposure,
    output logic           o_zero
);
    import alae_pkg::*;

    logic [15:0]       r_target, r_speed, r_min, r_max;
    logic [SUM_W-1:0]  r_rsum, r_gsum, r_bsum;
    logic [15:0]       r_elapsed;
    logic [W_W-1:0]    r_w;
    logic [DIV_W-1:0]  r_rem, r_d;
    logic [15:0]       r_q;
    logic              r_sat, r_zero;
    logic [31:0]       r_v, r_res, r_bit;
    logic [15:0]       r_root [1:ROOTS];
    logic [16:0]       r_acc;
    logic [15:0]       r_p;
    logic [32:0]       r_prod;
    logic [15:0]       r_exp;
    logic [15:0]       r_out_exp;
    logic              r_out_zero;

    logic [SUM_W-1:0]  mul_sum;
    logic [15:0]       mul_wt;
    logic [W_W-1:0]    wprod;
    logic [DIV_W-1:0]  num;
    logic [31:0]       sq_try;
    logic              sq_ge;
    logic [31:0]       n_v, n_res;
    logic [3:0]        rd_idx;
    logic [15:0]       rd_val;
    logic [15:0]       pow_f;
    logic [32:0]       acc_prod;
    logic [31:0]       p_prod;
    logic [15:0]       tgt;
    logic [33:0]       bl_sum;
    logic [15:0]       e_raw, e_hi, e_clamp;

    always_comb begin
        case (i_cmd.step)
            4'd0:    begin mul_sum = r_rsum; mul_wt = WEIGHT_RED;   end
            4'd1:    begin mul_sum = r_gsum; mul_wt = WEIGHT_GREEN; end
            default: begin mul_sum = r_bsum; mul_wt = WEIGHT_BLUE;  end
        endcase
    end
    assign wprod = W_W'(mul_sum) * W_W'(mul_wt);
    assign num   = DIV_W'({r_target, 24'd0}) * DIV_W'(NPIX);

    assign sq_try = r_res + r_bit;
    assign sq_ge  = r_v >= sq_try;
    assign n_v    = sq_ge ? r_v - sq_try : r_v;
    assign n_res  = sq_ge ? (r_res >> 1) + r_bit : r_res >> 1;

    assign rd_idx   = (i_cmd.op == OP_POW) ? 4'(ROOTS) - i_cmd.step : i_cmd.root - 4'd1;
    assign rd_val   = (rd_idx == 4'd0) ? r_speed : r_root[rd_idx];
    assign pow_f    = (i_cmd.step < 4'(ROOTS)) ? rd_val : r_p;
    assign acc_prod = 33'(r_acc) * 33'(pow_f);
    assign p_prod   = 32'(r_p) * 32'(r_p);

    assign tgt     = r_sat ? EXP_SAT : r_q;
    assign bl_sum  = 34'(r_prod) + 34'(33'(tgt) * 33'(ONE_Q16 - r_acc));
    assign e_raw   = bl_sum[31:16];
    assign e_hi    = (e_raw > r_max) ? r_max : e_raw;
    assign e_clamp = (e_hi < r_min) ? r_min : e_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= RST_TARGET;
            r_speed  <= RST_SPEED;
            r_min    <= RST_MIN;
            r_max    <= RST_MAX;
            r_rsum   <= '0;
            r_gsum   <= '0;
            r_bsum   <= '0;
            r_exp    <= EXP_ONE;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_TARGET: r_target <= i_cfg_data;
                    CFG_SPEED:  r_speed  <= i_cfg_data;
                    CFG_MIN:    r_min    <= i_cfg_data;
                    CFG_MAX:    r_max    <= i_cfg_data;
                    default:    r_target <= r_target;
                endcase
            end
            if (i_cmd.acc) begin
                r_rsum <= r_rsum + SUM_W'(i_red);
                r_gsum <= r_gsum + SUM_W'(i_green);
                r_bsum <= r_bsum + SUM_W'(i_blue);
            end else if (i_cmd.op == OP_BL2) begin
                r_rsum <= '0;
                r_gsum <= '0;
                r_bsum <= '0;
                r_exp  <= e_clamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_elapsed <= i_elapsed;
        end
        case (i_cmd.op)
            OP_WSUM: begin
                r_w <= ((i_cmd.step == 4'd0) ? '0 : r_w) + wprod;
            end
            OP_DINIT: begin
                r_rem  <= num;
                r_d    <= DIV_W'(r_w) << 15;
                r_q    <= '0;
                r_zero <= (r_w == '0);
                r_sat  <= (r_w == '0) || (num >= (DIV_W'(r_w) << 16));
            end
            OP_DIV: begin
                if (r_rem >= r_d) begin
                    r_rem <= r_rem - r_d;
                    r_q   <= r_q | (16'd1 << i_cmd.step);
                end
                r_d <= r_d >> 1;
            end
            OP_SINIT: begin
                r_v   <= {rd_val, 16'd0};
                r_res <= '0;
                r_bit <= 32'h4000_0000;
            end
            OP_SQRT: begin
                r_v   <= n_v;
                r_res <= n_res;
                r_bit <= r_bit >> 2;
                if (i_cmd.step == 4'd0) begin
                    r_root[i_cmd.root] <= n_res[15:0];
                end
            end
            OP_PINIT: begin
                r_acc <= ONE_Q16;
                r_p   <= r_speed;
            end
            OP_POW: begin
                if (r_elapsed[i_cmd.step]) begin
                    r_acc <= acc_prod[32:16];
                end
                if (i_cmd.step >= 4'(ROOTS)) begin
                    r_p <= p_prod[31:16];
                end
            end
            OP_BL1: begin
                r_prod <= 33'(r_exp) * 33'(r_acc);
            end
            OP_BL2: begin
                r_out_exp  <= e_clamp;
                r_out_zero <= r_zero;
            end
            default: r_q <= r_q;
        endcase
    end

    assign o_exposure = r_out_exp;
    assign o_zero     = r_out_zero;
endmodule

/* design/average_luminance_auto_exposure.sv */
`timescale 1ns / 1ps
// channel   dir  payload                                  transfer when
// i_pix     in   red, green, blue, elapsed_time           valid & ready
// o_res     out  new_exposure, luminance_zero             valid & ready
// i_cfg     in   i_cfg_idx, i_cfg_data                    i_cfg_we
// Pixels are taken one per cycle while accumulating; the frame's last pixel
// starts the frame math, during which no pixel is taken: luminance MAC,
// divide, ten 16-step square roots, the power loop, then the blend.
// The last pixel of the next frame waits while a result is still untaken.
// Synchronous active-low reset; state, config, sum and exposure regs reset.
module average_luminance_auto_exposure (
    input  logic            i_clk,
    input  logic            i_rst_n,
    alae_pix_if.sink        i_pix,
    alae_res_if.source      o_res,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [15:0]     i_cfg_data
);
    import alae_pkg::*;

    t_cmd cmd;

    alae_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .o_in_ready  (i_pix.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (cmd)
    );

    alae_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_red      (i_pix.red),
        .i_green    (i_pix.green),
        .i_blue     (i_pix.blue),
        .i_elapsed  (i_pix.elapsed_time),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_exposure (o_res.new_exposure),
        .o_zero     (o_res.luminance_zero)
    );
endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import alae_pkg::*;

    typedef struct {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] elapsed;
    } t_pix;

    typedef struct {
        logic [15:0] exposure;
        logic        zero;
        logic        known;
    } t_exp;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    alae_pix_if pix_if ();
    alae_res_if res_if ();

    average_luminance_auto_exposure u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_if.sink),
        .o_res      (res_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    localparam int LIMIT = 20000;

    logic [15:0] m_target, m_speed, m_min, m_max, m_exposure;
    logic [63:0] m_rsum, m_gsum, m_bsum;
    int          m_count;
    t_exp        exposure_q[$];
    int          errors;
    int          idle_cycles;
    bit          stall_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] isqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b   = 64'd1 << 30;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res[31:0];
    endfunction

    function automatic logic [31:0] decay_factor(logic [15:0] speed, logic [15:0] dt);
        logic [31:0] roots[11];
        logic [63:0] acc;
        logic [63:0] p;
        logic [63:0] f;
        acc      = 64'd65536;
        p        = speed;
        roots[0] = speed;
        for (int b = 1; b <= 10; b++) roots[b] = isqrt(64'(roots[b-1]) << 16);
        for (int b = 0; b < 16; b++) begin
            if (b < 10) begin
                f = roots[10 - b];
            end else begin
                f = p;
                p = (p * p) >> 16;
            end
            if (dt[b]) acc = (acc * f) >> 16;
        end
        return acc[31:0];
    endfunction

    task automatic reset_model();
        m_target   = RST_TARGET;
        m_speed    = RST_SPEED;
        m_min      = RST_MIN;
        m_max      = RST_MAX;
        m_exposure = EXP_ONE;
        m_rsum     = 0;
        m_gsum     = 0;
        m_bsum     = 0;
        m_count    = 0;
    endtask

    // returns 1 when the pixel closes a frame
    function automatic bit exposure_step(t_pix px, output t_exp r);
        logic [63:0] w, tgt, c, e;
        m_rsum += px.red;
        m_gsum += px.green;
        m_bsum += px.blue;
        r = '{0, 0, 1'b1};
        if (m_count + 1 < NPIX) begin
            m_count++;
            return 0;
        end
        w = 64'(WEIGHT_RED) * m_rsum + 64'(WEIGHT_GREEN) * m_gsum
            + 64'(WEIGHT_BLUE) * m_bsum;
        if (w == 0) begin
            tgt    = 65535;
            r.zero = 1'b1;
        end else begin
            tgt = ((64'(m_target) << 24) * NPIX) / w;
            if (tgt > 65535) tgt = 65535;
        end
        c = decay_factor(m_speed, px.elapsed);
        e = (64'(m_exposure) * c + tgt * (64'd65536 - c)) >> 16;
        if (e > m_max) e = m_max;
        if (e < m_min) e = m_min;
        m_exposure = e[15:0];
        r.exposure = e[15:0];
        m_rsum = 0;
        m_gsum = 0;
        m_bsum = 0;
        m_count = 0;
        return 1;
    endfunction

    task automatic send_pixel(t_pix px, t_exp fixed);
        t_exp r;
        pix_if.valid        <= 1'b1;
        pix_if.red          <= px.red;
        pix_if.green        <= px.green;
        pix_if.blue         <= px.blue;
        pix_if.elapsed_time <= px.elapsed;
        do @(posedge i_clk); while (!pix_if.ready);
        if (exposure_step(px, r)) begin
            if (fixed.known) r = fixed;
            exposure_q.push_back(r);
        end
    endtask

    task automatic drop_valid();
        pix_if.valid <= 1'b0;
    endtask

    task automatic drain();
        while (exposure_q.size() != 0) @(posedge i_clk);
        repeat (260) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_TARGET: m_target = val;
            CFG_SPEED:  m_speed  = val;
            CFG_MIN:    m_min    = val;
            CFG_MAX:    m_max    = val;
            default: ;
        endcase
    endtask

    task automatic cfg_done();
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_frame(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                              logic [15:0] dt, bit rnd, t_exp fixed);
        t_pix px;
        for (int i = 0; i < NPIX; i++) begin
            if (rnd) px = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
            else px = '{r, g, b, 16'($urandom)};
            if (i == NPIX - 1) px.elapsed = dt;
            send_pixel(px, fixed);
            if (!rnd && $urandom_range(0, 3) == 0) begin
                drop_valid();
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
        end
    endtask

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (($urandom & 63) == 0) stall_on <= ~stall_on;
        res_if.ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (exposure_q.size() == 0) begin
                $error("unexpected result exposure %0d", res_if.new_exposure);
                errors++;
            end else begin
                t_exp x;
                x = exposure_q.pop_front();
                if (res_if.new_exposure !== x.exposure) begin
                    $error("new_exposure expected %0d actual %0d",
                           x.exposure, res_if.new_exposure);
                    errors++;
                end
                if (res_if.luminance_zero !== x.zero) begin
                    $error("luminance_zero expected %0d actual %0d",
                           x.zero, res_if.luminance_zero);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)
            || (exposure_q.size() == 0 && !pix_if.valid))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= LIMIT) begin
            $display("FAIL average_luminance_auto_exposure");
            $finish;
        end
    end

    typedef struct {
        logic [15:0] r, g, b, dt;
        t_exp        fixed;
    } t_frame_row;

    t_frame_row table_rows[8];
    t_exp       none;

    initial begin
        errors       = 0;
        idle_cycles  = 0;
        stall_on     = 0;
        none         = '{0, 0, 1'b0};
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_TARGET;
        i_cfg_data   = 0;
        pix_if.valid = 1'b0;
        pix_if.red   = 0;
        pix_if.green = 0;
        pix_if.blue  = 0;
        pix_if.elapsed_time = 0;
        res_if.ready = 1'b1;
        reset_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // black frame with zero dt keeps exposure 4096, flags zero luminance
        table_rows[0] = '{16'h0000, 16'h0000, 16'h0000, 16'd0,      '{16'd4096, 1'b1, 1'b1}};
        // black frame, full dt: saturated target clamped to max
        table_rows[1] = '{16'h0000, 16'h0000, 16'h0000, 16'hFFFF,   '{16'd16384, 1'b1, 1'b1}};
        table_rows[2] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,   none};
        table_rows[3] = '{16'hFFFF, 16'h0000, 16'h0000, 16'd1024,   none};
        table_rows[4] = '{16'h0000, 16'hFFFF, 16'h0000, 16'd1,      none};
        table_rows[5] = '{16'h0000, 16'h0000, 16'h0001, 16'd2048,   none};
        table_rows[6] = '{16'h0100, 16'h0100, 16'h0100, 16'h5555,   none};
        table_rows[7] = '{16'h0001, 16'h0000, 16'h0000, 16'hAAAA,   none};
        foreach (table_rows[i])
            send_frame(table_rows[i].r, table_rows[i].g, table_rows[i].b,
                       table_rows[i].dt, 0, table_rows[i].fixed);
        drop_valid();
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_TARGET, 16'hFFFF);
                    write_reg(CFG_SPEED, 16'd0);
                    write_reg(CFG_MIN, 16'd0);
                    write_reg(CFG_MAX, 16'hFFFF);
                end
                1: begin
                    write_reg(CFG_TARGET, 16'd0);
                    write_reg(CFG_SPEED, 16'hFFFF);
                end
                2: begin
                    write_reg(CFG_MIN, 16'd9000);
                    write_reg(CFG_MAX, 16'd2000);
                    write_reg(CFG_TARGET, 16'd1229);
                end
                default: begin
                    write_reg(CFG_TARGET, 16'($urandom));
                    write_reg(CFG_SPEED, 16'($urandom));
                    write_reg(CFG_MIN, 16'($urandom_range(0, 8000)));
                    write_reg(CFG_MAX, 16'($urandom_range(8000, 65535)));
                end
            endcase
            cfg_done();
            for (int f = 0; f < 3; f++) begin
                t_pix px;
                int   lim;
                lim = $urandom_range(0, 3);
                for (int i = 0; i < NPIX; i++) begin
                    case (lim)
                        0: px = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
                        1: px = '{16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                                  16'($urandom_range(0, 3)), 16'($urandom_range(0, 3000))};
                        2: px = '{16'($urandom_range(0, 1024)), 16'($urandom_range(0, 1024)),
                                  16'($urandom_range(0, 1024)), 16'($urandom)};
                        default: px = '{16'hFFFF - 16'($urandom_range(0, 255)),
                                        16'($urandom), 16'hFFFF, 16'($urandom_range(0, 1))};
                    endcase
                    send_pixel(px, none);
                    if ($urandom_range(0, 15) == 0) begin
                        drop_valid();
                        repeat ($urandom_range(1, 6)) @(posedge i_clk);
                    end
                end
            end
            drop_valid();
            drain();
        end

        write_reg(CFG_TARGET, RST_TARGET);
        write_reg(CFG_SPEED, RST_SPEED);
        write_reg(CFG_MIN, RST_MIN);
        write_reg(CFG_MAX, RST_MAX);
        cfg_done();
        drop_valid();
        drain();
        if (errors == 0) begin
            $display("PASS average_luminance_auto_exposure");
        end else begin
            $display("FAIL average_luminance_auto_exposure");
        end
        $finish;
    end
endmodule
